>>> rtl/ksfs_pkg.sv
package ksfs_pkg;

    localparam int TOTAL_ENTRIES = 64;
    localparam int NUM_STACKS    = 4;
    localparam int SEG_SIZE      = TOTAL_ENTRIES / NUM_STACKS;

    localparam int DATA_W  = 32;
    localparam int SEL_W   = 2;
    localparam int ADDR_W  = $clog2(TOTAL_ENTRIES);
    localparam int FILL_W  = $clog2(SEG_SIZE + 1);
    localparam int STK_IW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int STAT_W  = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

>>> rtl/ksfs_dp.sv
module ksfs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ksfs_pkg::t_dp_cmd             i_cmd,
    input  logic                          i_opcode,
    input  logic [ksfs_pkg::DATA_W-1:0]   i_push_value,
    input  logic [ksfs_pkg::SEL_W-1:0]    i_stack_select,
    output logic [ksfs_pkg::DATA_W-1:0]   o_pop_value,
    output logic [ksfs_pkg::STAT_W-1:0]   o_status
);

    logic                          r_op;
    logic [ksfs_pkg::DATA_W-1:0]   r_value;
    logic [ksfs_pkg::SEL_W-1:0]    r_sel;

    logic [ksfs_pkg::FILL_W-1:0]   r_fill [ksfs_pkg::NUM_STACKS];
    logic [ksfs_pkg::DATA_W-1:0]   r_mem  [ksfs_pkg::TOTAL_ENTRIES];
    logic [ksfs_pkg::DATA_W-1:0]   r_rd_data;

    logic [ksfs_pkg::STAT_W-1:0]   r_res_status;
    logic [ksfs_pkg::DATA_W-1:0]   r_pop_value;
    logic [ksfs_pkg::STAT_W-1:0]   r_status;

    logic                          valid_stack;
    logic [ksfs_pkg::STK_IW-1:0]   stk_idx;
    logic [ksfs_pkg::FILL_W-1:0]   cur_fill;
    logic                          is_full;
    logic                          is_empty;
    logic                          push_ok;
    logic                          pop_ok;
    logic [ksfs_pkg::ADDR_W-1:0]   seg_base;
    logic [ksfs_pkg::ADDR_W-1:0]   push_addr;
    logic [ksfs_pkg::ADDR_W-1:0]   pop_addr;
    logic [ksfs_pkg::STAT_W-1:0]   n_res_status;

    assign valid_stack = ({1'b0, r_sel} < (ksfs_pkg::SEL_W + 1)'(ksfs_pkg::NUM_STACKS));
    assign stk_idx     = ksfs_pkg::STK_IW'(r_sel);
    assign cur_fill    = valid_stack ? r_fill[stk_idx] : '0;
    assign is_full     = !valid_stack || (cur_fill >= ksfs_pkg::FILL_W'(ksfs_pkg::SEG_SIZE));
    assign is_empty    = !valid_stack || (cur_fill == '0);
    assign push_ok     = (r_op == ksfs_pkg::OP_PUSH) && !is_full;
    assign pop_ok      = (r_op == ksfs_pkg::OP_POP) && !is_empty;

    assign seg_base  = ksfs_pkg::ADDR_W'(r_sel) * ksfs_pkg::ADDR_W'(ksfs_pkg::SEG_SIZE);
    assign push_addr = seg_base + ksfs_pkg::ADDR_W'(cur_fill);
    assign pop_addr  = push_addr - ksfs_pkg::ADDR_W'(1);

    always_comb begin
        if (r_op == ksfs_pkg::OP_PUSH) begin
            n_res_status = push_ok ? ksfs_pkg::ST_DONE : ksfs_pkg::ST_OVERFLOW;
        end else begin
            n_res_status = pop_ok ? ksfs_pkg::ST_DONE : ksfs_pkg::ST_UNDERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= i_opcode;
            r_value <= i_push_value;
            r_sel   <= i_stack_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ksfs_pkg::NUM_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (push_ok) begin
                r_fill[stk_idx] <= cur_fill + ksfs_pkg::FILL_W'(1);
            end else if (pop_ok) begin
                r_fill[stk_idx] <= cur_fill - ksfs_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && push_ok) begin
            r_mem[push_addr] <= r_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
        end
        if (i_cmd.load_out) begin
            r_status    <= r_res_status;
            r_pop_value <= ((r_op == ksfs_pkg::OP_POP) && (r_res_status == ksfs_pkg::ST_DONE))
                           ? r_rd_data : '0;
        end
    end

    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

endmodule

>>> rtl/ksfs_ctrl.sv
module ksfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ksfs_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_cmd.load_req = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/k_stacks_fixed_segments.sv
// Steps per request: capture in S_IDLE, stack update with one store access in S_EXEC,
// and output load in S_DONE once the output register is free to take the result.
// A new request is taken only after the previous one has been loaded for output.
// A stalled result waits in the output register while the next request is taken.
// Reset is synchronous and active low; it empties all stacks and drops m_axis_tvalid.
module k_stacks_fixed_segments (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ksfs_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] push_value
    input  logic [2:0]                    s_axis_tuser,  // [0] opcode, [2:1] stack_select
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ksfs_pkg::DATA_W-1:0]   m_axis_tdata,  // [31:0] pop_value
    output logic [ksfs_pkg::STAT_W-1:0]   m_axis_tuser   // [1:0] status
);

    ksfs_pkg::t_dp_cmd cmd;

    ksfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    ksfs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (s_axis_tuser[0]),
        .i_push_value   (s_axis_tdata),
        .i_stack_select (s_axis_tuser[2:1]),
        .o_pop_value    (m_axis_tdata),
        .o_status       (m_axis_tuser)
    );

endmodule

>>> rtl/ksfs_chk.sv
module ksfs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ksfs_pkg::DATA_W-1:0]   m_axis_tdata,
    input logic [ksfs_pkg::STAT_W-1:0]   m_axis_tuser
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ksfs_pkg::ST_DONE)
        || (m_axis_tuser == ksfs_pkg::ST_OVERFLOW) || (m_axis_tuser == ksfs_pkg::ST_UNDERFLOW))
        else $error("unknown status code");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ksfs_pkg::ST_DONE) |-> (m_axis_tdata == '0))
        else $error("refused request carries a nonzero value");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in progress");

endmodule

bind k_stacks_fixed_segments ksfs_chk u_ksfs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> verif/k_stacks_fixed_segments_tb.sv
module k_stacks_fixed_segments_tb;

    import ksfs_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] pop_value;
        logic [STAT_W-1:0] status;
    } stack_result_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata  = '0;  // [31:0] push_value
    logic [2:0]          s_axis_tuser  = '0;  // [0] opcode, [2:1] stack_select
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;        // [31:0] pop_value
    logic [STAT_W-1:0]   m_axis_tuser;        // [1:0] status

    logic [FILL_W-1:0]   stack_depth [NUM_STACKS];
    logic [DATA_W-1:0]   stack_words [TOTAL_ENTRIES];
    stack_result_t       pending_results [$];

    int                  error_count   = 0;
    bit                  src_idle_on   = 1'b1;
    bit                  sink_idle_on  = 1'b1;
    int                  hold_request  = 0;
    int                  hold_left     = 0;
    int                  stall_left    = 0;

    k_stacks_fixed_segments i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic stack_result_t apply_stack_request(input logic op,
                                                          input logic [DATA_W-1:0] val,
                                                          input logic [SEL_W-1:0] sel);
        stack_result_t res;
        int            idx;
        res.pop_value = '0;
        res.status    = ST_DONE;
        idx           = int'(sel);
        if (op == OP_PUSH) begin
            if (idx >= NUM_STACKS || int'(stack_depth[idx]) >= SEG_SIZE) begin
                res.status = ST_OVERFLOW;
            end else begin
                stack_words[idx * SEG_SIZE + int'(stack_depth[idx])] = val;
                stack_depth[idx] = stack_depth[idx] + 1'b1;
            end
        end else begin
            if (idx >= NUM_STACKS || stack_depth[idx] == '0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.pop_value = stack_words[idx * SEG_SIZE + int'(stack_depth[idx]) - 1];
                stack_depth[idx] = stack_depth[idx] - 1'b1;
            end
        end
        return res;
    endfunction

    task automatic send_request(input logic op, input logic [DATA_W-1:0] val,
                                input logic [SEL_W-1:0] sel);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= {sel, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_stack_request(op, val, sel));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Ready side: a long hold-off on request, otherwise random stall bursts.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        stack_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result beat with nothing expected, pop_value %h status %0d",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.pop_value) begin
                    error_count++;
                    $display("%0t: pop_value mismatch, expected %h actual %h",
                             $time, want.pop_value, m_axis_tdata);
                end
                if (m_axis_tuser !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                end
            end
        end
    end

    task automatic test_directed();
        for (int s = 0; s < NUM_STACKS; s++) send_request(OP_POP, 32'hFFFF_FFFF, SEL_W'(s));
        send_request(OP_PUSH, 32'h8000_0000, 2'd0);
        send_request(OP_PUSH, 32'h7FFF_FFFF, 2'd1);
        send_request(OP_PUSH, 32'hFFFF_FFFF, 2'd2);
        send_request(OP_PUSH, 32'h0000_0000, 2'd3);
        send_request(OP_PUSH, 32'h5555_5555, 2'd0);
        send_request(OP_PUSH, 32'hAAAA_AAAA, 2'd3);
        send_request(OP_POP, 32'h1234_5678, 2'd0);
        send_request(OP_POP, 32'h0, 2'd0);
        send_request(OP_POP, 32'h0, 2'd1);
        send_request(OP_POP, 32'hFFFF_FFFF, 2'd2);
        send_request(OP_POP, 32'h0, 2'd3);
        send_request(OP_POP, 32'h0, 2'd3);
    endtask

    task automatic test_fill_drain();
        for (int k = 0; k < SEG_SIZE; k++)
            for (int s = 0; s < NUM_STACKS; s++) send_request(OP_PUSH, pick_word(), SEL_W'(s));
        for (int s = 0; s < NUM_STACKS; s++) send_request(OP_PUSH, pick_word(), SEL_W'(s));
        for (int k = 0; k < SEG_SIZE; k++)
            for (int s = 0; s < NUM_STACKS; s++) send_request(OP_POP, $urandom, SEL_W'(s));
        for (int s = 0; s < NUM_STACKS; s++) send_request(OP_POP, $urandom, SEL_W'(s));
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_request = 80;
        for (int n = 0; n < 24; n++)
            send_request(1'($urandom_range(0, 1)), pick_word(), SEL_W'($urandom));
        wait_drained();
    endtask

    task automatic test_random(input int count);
        int push_pct;
        int focus;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 4))
                    0:       push_pct = 10;
                    1:       push_pct = 25;
                    2:       push_pct = 50;
                    3:       push_pct = 75;
                    default: push_pct = 90;
                endcase
                focus = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NUM_STACKS - 1) : -1;
            end
            send_request(($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP, pick_word(),
                         (focus >= 0) ? SEL_W'(focus) : SEL_W'($urandom));
        end
    endtask

    initial begin
        for (int s = 0; s < NUM_STACKS; s++) stack_depth[s] = '0;
        for (int a = 0; a < TOTAL_ENTRIES; a++) stack_words[a] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_drain();
        test_backpressure();
        test_random(1100);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random(250);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
